/* hdl/yrgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_pkg
// Types and fixed constants shared by the 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

   // Chroma bytes carry an offset of 128; flipping the top bit removes it.
   localparam logic [7:0] CHROMA_BIAS = 8'h80;

   // Conversion ratios: offset = (chroma * MUL) / DIV, truncated toward zero.
   localparam int RED_MUL     = 419;
   localparam int RED_DIV     = 299;
   localparam int GRN_V_MUL   = 299;
   localparam int GRN_V_DIV   = 419;
   localparam int GRN_U_MUL   = 114;
   localparam int GRN_U_DIV   = 331;
   localparam int BLU_MUL     = 587;
   localparam int BLU_DIV     = 331;

   // Reciprocal division: estimate = (mag * floor(2^SHIFT / d)) >> SHIFT.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_RED   = (1 << RECIP_SHIFT) / RED_DIV;
   localparam int RECIP_GRN_V = (1 << RECIP_SHIFT) / GRN_V_DIV;
   localparam int RECIP_GRN_U = (1 << RECIP_SHIFT) / GRN_U_DIV;
   localparam int RECIP_BLU   = (1 << RECIP_SHIFT) / BLU_DIV;

   localparam int MAG_W = 17;  // largest product is 128 * 587
   localparam int DIV_W = 10;  // divisors and multipliers fit in 10 bits
   localparam int REC_W = 16;  // reciprocals stay below 2^16
   localparam int QUO_W = 10;  // signed quotient, magnitude at most 226
   localparam int PIX_W = 11;  // luma plus offset before clamping

   localparam logic [7:0] PIX_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } req_type;

   typedef struct packed {
      logic [7:0] tl_red;
      logic [7:0] tl_green;
      logic [7:0] tl_blue;
      logic [7:0] tr_red;
      logic [7:0] tr_green;
      logic [7:0] tr_blue;
      logic [7:0] bl_red;
      logic [7:0] bl_green;
      logic [7:0] bl_blue;
      logic [7:0] br_red;
      logic [7:0] br_green;
      logic [7:0] br_blue;
   } rsp_type;

   // Stage loads for the two divider stages.
   typedef struct packed {
      logic load_est;
      logic load_fix;
   } div_ctl_type;

endpackage

/* hdl/yrgb_cdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_cdiv
// Two-stage signed division of a product magnitude by a fixed constant,
// truncating toward zero, using a reciprocal estimate and one correction.
// ----------------------------------------------------------------------------
module yrgb_cdiv import yrgb_pkg::*; (
   input  logic                    clock,
   input  div_ctl_type             ctl,
   input  logic [MAG_W-1:0]        mag_in,
   input  logic                    neg_in,
   input  logic [DIV_W-1:0]        divisor,
   input  logic [REC_W-1:0]        recip,
   output logic signed [QUO_W-1:0] quo
);

   logic [MAG_W+REC_W-1:0] prod;
   logic [QUO_W-2:0]       est_in;
   logic [QUO_W-2:0]       est_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic                   neg_ff;
   logic [MAG_W-1:0]       rem;
   logic [QUO_W-2:0]       q_fix;
   logic signed [QUO_W-1:0] quo_in;
   logic signed [QUO_W-1:0] quo_ff;

   // The estimate is never high and at most one below the true quotient.
   always_comb begin
      prod   = (MAG_W+REC_W)'(mag_in) * (MAG_W+REC_W)'(recip);
      est_in = prod[RECIP_SHIFT +: QUO_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_est) begin
         est_ff <= est_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   always_comb begin
      rem    = mag_ff - MAG_W'(MAG_W'(est_ff) * MAG_W'(divisor));
      q_fix  = (rem >= MAG_W'(divisor)) ? est_ff + 1'b1 : est_ff;
      quo_in = neg_ff ? -signed'({1'b0, q_fix}) : signed'({1'b0, q_fix});
   end

   always_ff @(posedge clock) begin
      if (ctl.load_fix) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

/* hdl/yuv420_block_to_rgb_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_core
// Converts one 2x2 block of a 4:2:0 frame into twelve clamped RGB bytes.
// ----------------------------------------------------------------------------
// Usage: a request carries four luma bytes and the shared U and V bytes of a
// 2x2 block on req_data and is taken when req_valid and req_ready are high.
// The response on rsp_data holds the red, green and blue bytes of all four
// pixels and is delivered when rsp_valid and rsp_ready are high.
// The pipeline has five register stages: chroma bias removal, constant
// products, reciprocal estimate, quotient correction, and luma add with
// clamping. One request is taken every cycle while the receiver keeps up.
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves on, so bubbles close up while the receiver stalls and
// a request is still taken as long as any stage ahead has room. The block
// keeps no state between requests. Reset empties the pipeline; nothing
// else needs clearing.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_core import yrgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] rdy;

   // Stage 1: chroma without bias, luma carried along
   logic signed [7:0] u_ff, v_ff;
   logic [7:0]        luma1_ff [4];

   // Stage 2: product magnitudes and quotient signs
   logic [MAG_W-1:0] red_mag_ff, gv_mag_ff, gu_mag_ff, blu_mag_ff;
   logic             red_neg_ff, gv_neg_ff, gu_neg_ff, blu_neg_ff;
   logic [7:0]       luma2_ff [4];
   logic [7:0]       u_abs, v_abs;

   // Stages 3 and 4 live in the dividers
   logic [7:0] luma3_ff [4];
   logic [7:0] luma4_ff [4];
   logic signed [QUO_W-1:0] red_q, gv_q, gu_q, blu_q;
   div_ctl_type div_ctl;

   // Stage 5: output
   logic signed [PIX_W-1:0] red_off, grn_off, blu_off;
   logic [7:0]              pix_in [4][3];
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;

   function automatic logic [7:0] clamp_pix(input logic [7:0] luma,
                                            input logic signed [PIX_W-1:0] off);
      logic signed [PIX_W-1:0] sum;
      begin
         sum = signed'(PIX_W'(luma)) + off;
         if (sum < 0) begin
            clamp_pix = 8'd0;
         end else if (sum > signed'(PIX_W'(PIX_MAX))) begin
            clamp_pix = PIX_MAX;
         end else begin
            clamp_pix = sum[7:0];
         end
      end
   endfunction

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         u_ff        <= signed'(req_data.chroma_u ^ CHROMA_BIAS);
         v_ff        <= signed'(req_data.chroma_v ^ CHROMA_BIAS);
         luma1_ff[0] <= req_data.luma_top_left;
         luma1_ff[1] <= req_data.luma_top_right;
         luma1_ff[2] <= req_data.luma_bottom_left;
         luma1_ff[3] <= req_data.luma_bottom_right;
      end
   end

   // The magnitude of -128 is 128, which still fits in eight unsigned bits.
   always_comb begin
      u_abs = u_ff[7] ? 8'(-u_ff) : 8'(u_ff);
      v_abs = v_ff[7] ? 8'(-v_ff) : 8'(v_ff);
   end

   // Green uses negative ratios, so its quotients are negative for positive
   // chroma. A zero product gives zero either way.
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         red_mag_ff <= MAG_W'(v_abs) * MAG_W'(RED_MUL);
         gv_mag_ff  <= MAG_W'(v_abs) * MAG_W'(GRN_V_MUL);
         gu_mag_ff  <= MAG_W'(u_abs) * MAG_W'(GRN_U_MUL);
         blu_mag_ff <= MAG_W'(u_abs) * MAG_W'(BLU_MUL);
         red_neg_ff <= v_ff[7];
         gv_neg_ff  <= !v_ff[7];
         gu_neg_ff  <= !u_ff[7];
         blu_neg_ff <= u_ff[7];
         luma2_ff   <= luma1_ff;
      end
   end

   always_comb begin
      div_ctl.load_est = rdy[2];
      div_ctl.load_fix = rdy[3];
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         luma3_ff <= luma2_ff;
      end
      if (rdy[3]) begin
         luma4_ff <= luma3_ff;
      end
   end

   yrgb_cdiv u_div_red (
      .clock   (clock),
      .ctl     (div_ctl),
      .mag_in  (red_mag_ff),
      .neg_in  (red_neg_ff),
      .divisor (DIV_W'(RED_DIV)),
      .recip   (REC_W'(RECIP_RED)),
      .quo     (red_q)
   );

   yrgb_cdiv u_div_gv (
      .clock   (clock),
      .ctl     (div_ctl),
      .mag_in  (gv_mag_ff),
      .neg_in  (gv_neg_ff),
      .divisor (DIV_W'(GRN_V_DIV)),
      .recip   (REC_W'(RECIP_GRN_V)),
      .quo     (gv_q)
   );

   yrgb_cdiv u_div_gu (
      .clock   (clock),
      .ctl     (div_ctl),
      .mag_in  (gu_mag_ff),
      .neg_in  (gu_neg_ff),
      .divisor (DIV_W'(GRN_U_DIV)),
      .recip   (REC_W'(RECIP_GRN_U)),
      .quo     (gu_q)
   );

   yrgb_cdiv u_div_blu (
      .clock   (clock),
      .ctl     (div_ctl),
      .mag_in  (blu_mag_ff),
      .neg_in  (blu_neg_ff),
      .divisor (DIV_W'(BLU_DIV)),
      .recip   (REC_W'(RECIP_BLU)),
      .quo     (blu_q)
   );

   always_comb begin
      red_off = PIX_W'(red_q);
      grn_off = PIX_W'(gv_q) + PIX_W'(gu_q);
      blu_off = PIX_W'(blu_q);
      for (int p = 0; p < 4; p++) begin
         pix_in[p][0] = clamp_pix(luma4_ff[p], red_off);
         pix_in[p][1] = clamp_pix(luma4_ff[p], grn_off);
         pix_in[p][2] = clamp_pix(luma4_ff[p], blu_off);
      end
      rsp_in.tl_red   = pix_in[0][0];
      rsp_in.tl_green = pix_in[0][1];
      rsp_in.tl_blue  = pix_in[0][2];
      rsp_in.tr_red   = pix_in[1][0];
      rsp_in.tr_green = pix_in[1][1];
      rsp_in.tr_blue  = pix_in[1][2];
      rsp_in.bl_red   = pix_in[2][0];
      rsp_in.bl_green = pix_in[2][1];
      rsp_in.bl_blue  = pix_in[2][2];
      rsp_in.br_red   = pix_in[3][0];
      rsp_in.br_green = pix_in[3][1];
      rsp_in.br_blue  = pix_in[3][2];
   end

   always_ff @(posedge clock) begin
      if (rdy[STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

   // A stalled response stays in the output stage.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1] && !rsp_ready |=> vld_ff[STAGES-1])
      else $error("response dropped while stalled");

   // The output stage only empties through a completed handshake.
   assert property (@(posedge clock) disable iff (reset)
      $fell(vld_ff[STAGES-1]) |-> $past(rsp_ready))
      else $error("response vanished without handshake");

   // An accepted request always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request lost at entry");

   // A full middle stage that cannot move keeps its item.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && !rdy[3] |=> vld_ff[2])
      else $error("item lost in divider stage");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
// A short directed table covers neutral chroma, the chroma extremes, luma at
// both rails and negative quotients that must truncate toward zero. A few
// rows carry hand-worked RGB bytes. The predictor checks every other row and
// the random blocks that follow. The random part runs in four phases of
// sender gaps and receiver stalls. Every response is compared byte by byte
// with the oldest outstanding request.
// ----------------------------------------------------------------------------
module tb import yrgb_pkg::*; ();

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PER_PHASE = 160;

   // Conversion ratios, with the green terms carrying their negative sign.
   localparam int V_TO_RED_MUL = 419;
   localparam int V_TO_RED_DIV = 299;
   localparam int V_TO_GRN_MUL = -299;
   localparam int V_TO_GRN_DIV = 419;
   localparam int U_TO_GRN_MUL = -114;
   localparam int U_TO_GRN_DIV = 331;
   localparam int U_TO_BLU_MUL = 587;
   localparam int U_TO_BLU_DIV = 331;

   typedef struct {
      req_type blk;
      bit      has_gold;
      rsp_type gold;
   } block_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Hand-worked answer that travels alongside the request payload.
   logic    req_gold_on;
   rsp_type req_gold;

   rsp_type       rgb_expected[$];
   rsp_type       rgb_want;
   block_row_type block_rows[$];
   int unsigned   send_idle_pct;
   int unsigned   rsp_stall_pct;
   int unsigned   cycle_count = 0;
   int unsigned   error_count = 0;
   int unsigned   blocks_taken = 0;
   int unsigned   blocks_checked = 0;

   string rgb_field_name[12] = '{"tl_red", "tl_green", "tl_blue",
                                 "tr_red", "tr_green", "tr_blue",
                                 "bl_red", "bl_green", "bl_blue",
                                 "br_red", "br_green", "br_blue"};

   yuv420_block_to_rgb_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [7:0] clamp_byte(input int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return x[7:0];
   endfunction

   // SystemVerilog signed division truncates toward zero, as the block must.
   function automatic rsp_type predict_rgb(input req_type blk);
      int          u;
      int          v;
      int          red_off;
      int          grn_off;
      int          blu_off;
      int          luma [4];
      logic [95:0] px;
      luma[0] = int'(blk.luma_top_left);
      luma[1] = int'(blk.luma_top_right);
      luma[2] = int'(blk.luma_bottom_left);
      luma[3] = int'(blk.luma_bottom_right);
      u = int'(blk.chroma_u) - 128;
      v = int'(blk.chroma_v) - 128;
      red_off = (v * V_TO_RED_MUL) / V_TO_RED_DIV;
      grn_off = (v * V_TO_GRN_MUL) / V_TO_GRN_DIV + (u * U_TO_GRN_MUL) / U_TO_GRN_DIV;
      blu_off = (u * U_TO_BLU_MUL) / U_TO_BLU_DIV;
      for (int k = 0; k < 4; k++) begin
         px[95 - 24*k -: 8] = clamp_byte(luma[k] + red_off);
         px[87 - 24*k -: 8] = clamp_byte(luma[k] + grn_off);
         px[79 - 24*k -: 8] = clamp_byte(luma[k] + blu_off);
      end
      return rsp_type'(px);
   endfunction

   // Mostly uniform bytes, with the rails and the chroma midpoint favored.
   function automatic logic [7:0] pick_byte(input bit is_chroma);
      logic [7:0] rails [4];
      if (is_chroma) rails = '{8'd0, 8'd127, 8'd128, 8'd255};
      else rails = '{8'd0, 8'd1, 8'd254, 8'd255};
      if ($urandom_range(99) < 15) return rails[2'($urandom_range(3))];
      return 8'($urandom_range(255));
   endfunction

   function automatic req_type random_block();
      req_type blk;
      blk.luma_top_left     = pick_byte(1'b0);
      blk.luma_top_right    = pick_byte(1'b0);
      blk.luma_bottom_left  = pick_byte(1'b0);
      blk.luma_bottom_right = pick_byte(1'b0);
      blk.chroma_u          = pick_byte(1'b1);
      blk.chroma_v          = pick_byte(1'b1);
      return blk;
   endfunction

   task automatic add_row(input logic [7:0] tl, input logic [7:0] tr, input logic [7:0] bl,
                          input logic [7:0] br, input logic [7:0] u, input logic [7:0] v,
                          input bit has_gold = 1'b0, input rsp_type gold = '0);
      block_row_type row;
      row.blk      = '{tl, tr, bl, br, u, v};
      row.has_gold = has_gold;
      row.gold     = gold;
      block_rows.push_back(row);
   endtask

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_block(input req_type blk, input bit has_gold, input rsp_type gold);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= blk;
      req_gold_on <= has_gold;
      req_gold    <= gold;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, rgb_expected.size());
         $display("yuv420_block_to_rgb_core regression: fail");
         $finish;
      end
   end

   // The request side is handled first so a response can never overtake it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            rgb_expected.push_back(req_gold_on ? req_gold : predict_rgb(req_data));
            blocks_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            blocks_checked++;
            if (rgb_expected.size() == 0) begin
               $error("response %h arrived with no request outstanding", rsp_data);
               error_count++;
            end else begin
               rgb_want = rgb_expected.pop_front();
               for (int k = 0; k < 12; k++) begin
                  if (rsp_data[95 - 8*k -: 8] !== rgb_want[95 - 8*k -: 8]) begin
                     $error("%s: expected %0d, got %0d", rgb_field_name[k],
                            rgb_want[95 - 8*k -: 8], rsp_data[95 - 8*k -: 8]);
                     error_count++;
                  end
               end
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      req_gold_on    = 1'b0;
      req_gold       = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;

      // Neutral chroma: every channel equals the pixel's luma.
      add_row(8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd128, 1'b1,
              '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
      add_row(8'd1, 8'd128, 8'd127, 8'd254, 8'd128, 8'd128, 1'b1,
              '{8'd1, 8'd1, 8'd1, 8'd128, 8'd128, 8'd128,
                8'd127, 8'd127, 8'd127, 8'd254, 8'd254, 8'd254});
      // Both chroma bytes at the bottom: offsets -179, +135, -226.
      add_row(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1,
              '{8'd0, 8'd135, 8'd0, 8'd76, 8'd255, 8'd29,
                8'd0, 8'd135, 8'd0, 8'd76, 8'd255, 8'd29});
      // Both chroma bytes at the top: offsets +177, -133, +225.
      add_row(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1,
              '{8'd177, 8'd0, 8'd225, 8'd255, 8'd122, 8'd255,
                8'd177, 8'd0, 8'd225, 8'd255, 8'd122, 8'd255});
      // Small negative products that must round toward zero.
      add_row(8'd100, 8'd1, 8'd0, 8'd255, 8'd127, 8'd127);
      add_row(8'd100, 8'd1, 8'd0, 8'd255, 8'd126, 8'd125);
      add_row(8'd100, 8'd1, 8'd0, 8'd255, 8'd129, 8'd129);
      add_row(8'd60, 8'd200, 8'd0, 8'd255, 8'd0, 8'd255);
      add_row(8'd60, 8'd200, 8'd0, 8'd255, 8'd255, 8'd0);
      add_row(8'd177, 8'd178, 8'd30, 8'd29, 8'd0, 8'd0);
      add_row(8'd78, 8'd79, 8'd132, 8'd133, 8'd255, 8'd255);
      add_row(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA);
      add_row(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55);
      add_row(8'd16, 8'd235, 8'd16, 8'd235, 8'd16, 8'd240);
      add_row(8'd250, 8'd5, 8'd128, 8'd64, 8'd1, 8'd254);
      add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd127, 8'd128);
      add_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd127);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (block_rows[i])
         send_block(block_rows[i].blk, block_rows[i].has_gold, block_rows[i].gold);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 66;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_block(random_block(), 1'b0, '0);
      end

      req_valid   <= 1'b0;
      req_gold_on <= 1'b0;
      rsp_stall_pct = 0;
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d blocks sent (%0d directed), %0d responses checked over four pacing phases",
               blocks_taken, block_rows.size(), blocks_checked);
      $display("%0d mismatches in %0d cycles", error_count, cycle_count);
      if (error_count == 0)
         $display("yuv420_block_to_rgb_core regression: pass");
      else
         $display("yuv420_block_to_rgb_core regression: fail");
      $finish;
   end

endmodule
